/* hw/rtl/table_driven_pushdown_automaton_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the pushdown automaton block
// Every use expects clk_i and rst_ni in the scope of the module.
// ---------------------------------------------------------------------------
`ifndef TABLE_DRIVEN_PUSHDOWN_AUTOMATON_MACROS_SVH
`define TABLE_DRIVEN_PUSHDOWN_AUTOMATON_MACROS_SVH

// same-cycle implication
`define TDPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tdpa_pkg.sv */
// ---------------------------------------------------------------------------
// tdpa_pkg
// Types, codes and helper functions of the bracket pushdown automaton.
// ---------------------------------------------------------------------------
package tdpa_pkg;

  // automaton state, alphabet and stack code counts
  localparam int NumStates  = 2;
  localparam int NumSymbols = 4;
  localparam int NumTops    = 6;

  // stack codes and rule actions
  localparam logic [2:0] CODE_P   = 3'd4;
  localparam logic [2:0] CODE_Z   = 3'd5;
  localparam logic [2:0] ACT_POP  = 3'd6;
  localparam logic [2:0] ACT_KEEP = 3'd7;

  // rule kinds
  localparam logic [1:0] KIND_GOTO = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_KEEP = 2'd2;

  // item operations
  typedef enum logic [1:0] {
    OP_FEED    = 2'd0,
    OP_RULE    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_MOVED      = 3'd0,
    ST_ACCEPTED   = 3'd1,
    ST_NO_RULE    = 3'd2,
    ST_BAD_SYMBOL = 3'd3,
    ST_EMPTIED    = 3'd4,
    ST_OVERFLOW   = 3'd5,
    ST_HALTED     = 3'd6,
    ST_DONE       = 3'd7
  } status_e;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_EMIT
  } fsm_e;

  // one rule table entry
  typedef struct packed {
    logic       next_state;
    logic [2:0] act;
  } rule_t;

  // decoded input character
  typedef struct packed {
    logic       bad;
    logic [1:0] code;
  } sym_t;

  // map a raw character to its bracket code
  function automatic sym_t sym_decode(input logic [7:0] byte_in);
    sym_t s;
    s.bad  = 1'b0;
    s.code = 2'd0;
    case (byte_in)
      8'h7B: s.code = 2'd0;
      8'h5B: s.code = 2'd1;
      8'h7D: s.code = 2'd2;
      8'h5D: s.code = 2'd3;
      default: s.bad = 1'b1;
    endcase
    return s;
  endfunction

  // turn a rule item into the stored next state and action
  function automatic rule_t rule_encode(input logic [1:0] kind, input logic [2:0] push,
                                        input logic st, input logic nxt,
                                        input logic [1:0] sym, input logic [2:0] top);
    rule_t r;
    r.next_state = st;
    r.act        = ACT_KEEP;
    case (kind)
      KIND_GOTO: r.next_state = nxt;
      KIND_POP:  r.act = ACT_POP;
      KIND_KEEP: r.act = ACT_KEEP;
      default: begin
        if (push == CODE_P) begin
          r.act = ACT_POP;
        end else if (push > CODE_Z) begin
          r.act = ACT_KEEP;
        end else begin
          r.act = push;
        end
      end
    endcase
    // state 0 over the bottom marker always pushes its own symbol
    if (!st && top == CODE_Z) begin
      r.act = {1'b0, sym};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/tdpa_ram.sv */
// ---------------------------------------------------------------------------
// tdpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tdpa_ram #(
  parameter int Width = 4,
  parameter int Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/table_driven_pushdown_automaton.sv */
// ---------------------------------------------------------------------------
// table_driven_pushdown_automaton
// Bracket pushdown automaton: rule table and stack held in RAMs.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i/in_ready_o) carries one item: feed a symbol,
//   write a rule, or restart. Each item yields exactly one result item on
//   the output channel (out_valid_o/out_ready_i): status, state, stack top
//   and stack depth after the item.
//   The config channel (cfg_valid_i/cfg_ready_o) writes the start state; it
//   is always ready. The user must write it only while the block is idle,
//   which the block itself does not enforce.
// Sequencing
//   Rule writes, restarts, halted and rejected symbols go from S_IDLE
//   straight to S_EMIT; other symbols pass S_EXEC (rule RAM read), and a
//   pop that leaves two or more entries also S_POP (stack RAM read of the
//   new top). One item is in flight at a time; a new one waits for S_IDLE.
// Reset and stalls
//   Reset clears all rules, leaves the stack with the Z marker only and
//   enters state 0. The result waits in the output register while the
//   receiver stalls; the next item is taken meanwhile and its own result
//   is held until the output register frees up.
// ---------------------------------------------------------------------------
`include "table_driven_pushdown_automaton_macros.svh"

module table_driven_pushdown_automaton import tdpa_pkg::*; #(
  parameter int STACK_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_data_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic [7:0]                         symbol_byte_i,
  input  logic                               rule_state_i,
  input  logic [1:0]                         rule_symbol_i,
  input  logic [2:0]                         rule_stack_top_i,
  input  logic [1:0]                         rule_kind_i,
  input  logic                               rule_next_state_i,
  input  logic [2:0]                         rule_push_code_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [2:0]                         status_o,
  output logic                               current_state_o,
  output logic [2:0]                         top_code_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   stack_depth_o
);

  localparam int TblDepth = NumStates * NumSymbols * NumTops;
  localparam int RiW      = $clog2(TblDepth);
  localparam int SpW      = $clog2(STACK_DEPTH + 1);
  localparam int SaW      = $clog2(STACK_DEPTH);
  localparam logic [SpW-1:0] SpFull = SpW'(STACK_DEPTH);
  localparam logic [SpW-1:0] SpOne  = SpW'(1);
  localparam logic [SpW-1:0] SpTwo  = SpW'(2);

  // architectural state
  fsm_e              fsm_q, fsm_d;
  logic              start_q, start_d;
  logic              state_q, state_d;
  logic [2:0]        top_q, top_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic              halted_q, halted_d;
  status_e           status_q, status_d;
  logic [RiW-1:0]    ridx_q, ridx_d;
  logic [TblDepth-1:0] valid_q, valid_d;

  // output register
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic              out_state_q;
  logic [2:0]        out_top_q;
  logic [SpW-1:0]    out_sp_q;

  // memory ports
  logic              rule_we, rule_re;
  logic [RiW-1:0]    rule_waddr, rule_raddr;
  rule_t             rule_wdata, rule_rdata;
  logic              stk_we, stk_re;
  logic [SaW-1:0]    stk_waddr, stk_raddr;
  logic [2:0]        stk_wdata, stk_rdata;

  // item decode
  logic              in_acc;
  sym_t              sym;
  logic              accepting;
  logic              key_ok;
  logic              emit_go;
  logic [SpW-1:0]    sp_m2;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (fsm_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign sym        = sym_decode(symbol_byte_i);
  assign accepting  = state_q && (sp_q != '0) && (top_q == CODE_Z);
  assign key_ok     = (rule_stack_top_i < 3'(NumTops)) && (int'(rule_state_i) < NumStates);
  assign emit_go    = (fsm_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign sp_m2      = sp_q - SpTwo;

  // rule table lookup and write addresses
  assign rule_raddr = RiW'((RiW'(state_q) * RiW'(NumSymbols) + RiW'(sym.code))
                           * RiW'(NumTops) + RiW'(top_q));
  assign rule_waddr = RiW'((RiW'(rule_state_i) * RiW'(NumSymbols) + RiW'(rule_symbol_i))
                           * RiW'(NumTops) + RiW'(rule_stack_top_i));
  assign rule_wdata = rule_encode(rule_kind_i, rule_push_code_i, rule_state_i,
                                  rule_next_state_i, rule_symbol_i, rule_stack_top_i);
  assign rule_we    = in_acc && (op_e'(operation_i) == OP_RULE) && key_ok;
  assign rule_re    = in_acc;

  tdpa_ram #(
    .Width ($bits(rule_t)),
    .Depth (TblDepth)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (rule_we),
    .waddr_i (rule_waddr),
    .wdata_i (rule_wdata),
    .re_i    (rule_re),
    .raddr_i (rule_raddr),
    .rdata_o (rule_rdata)
  );

  tdpa_ram #(
    .Width (3),
    .Depth (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // sequencer next state
  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: begin
        if (in_acc) begin
          if (op_e'(operation_i) == OP_FEED && !halted_q && !accepting && !sym.bad) begin
            fsm_d = S_EXEC;
          end else begin
            fsm_d = S_EMIT;
          end
        end
      end
      S_EXEC: begin
        if (valid_q[ridx_q] && rule_rdata.act == ACT_POP && sp_q > SpTwo) begin
          fsm_d = S_POP;
        end else begin
          fsm_d = S_EMIT;
        end
      end
      S_POP: fsm_d = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          fsm_d = S_IDLE;
        end
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    start_d   = start_q;
    state_d   = state_q;
    top_d     = top_q;
    sp_d      = sp_q;
    halted_d  = halted_q;
    status_d  = status_q;
    ridx_d    = ridx_q;
    valid_d   = valid_q;
    stk_we    = 1'b0;
    stk_waddr = sp_q[SaW-1:0];
    stk_wdata = rule_rdata.act;
    stk_re    = 1'b0;
    stk_raddr = sp_m2[SaW-1:0];

    if (cfg_valid_i && cfg_ready_o) begin
      start_d = cfg_data_i;
    end

    case (fsm_q)
      // take an item; settle everything that needs no lookup
      S_IDLE: begin
        if (in_acc) begin
          ridx_d   = rule_raddr;
          status_d = ST_DONE;
          case (op_e'(operation_i))
            OP_FEED: begin
              if (halted_q) begin
                status_d = ST_HALTED;
              end else if (accepting) begin
                status_d = ST_ACCEPTED;
                halted_d = 1'b1;
              end else if (sym.bad) begin
                status_d = ST_BAD_SYMBOL;
                halted_d = 1'b1;
              end
            end
            OP_RULE: begin
              if (key_ok) begin
                valid_d[rule_waddr] = 1'b1;
              end
            end
            OP_RESTART: begin
              state_d  = start_q;
              top_d    = CODE_Z;
              sp_d     = SpOne;
              halted_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // apply the looked-up rule
      S_EXEC: begin
        if (!valid_q[ridx_q]) begin
          status_d = ST_NO_RULE;
          halted_d = 1'b1;
        end else begin
          case (rule_rdata.act)
            ACT_POP: begin
              state_d = rule_rdata.next_state;
              sp_d    = sp_q - SpOne;
              if (sp_q == SpOne) begin
                top_d    = CODE_Z;
                status_d = ST_EMPTIED;
                halted_d = 1'b1;
              end else if (sp_q == SpTwo) begin
                // only the bottom marker remains
                top_d    = CODE_Z;
                status_d = rule_rdata.next_state ? ST_ACCEPTED : ST_MOVED;
                halted_d = rule_rdata.next_state;
              end else begin
                stk_re = 1'b1;
              end
            end
            ACT_KEEP: begin
              state_d  = rule_rdata.next_state;
              status_d = (rule_rdata.next_state && top_q == CODE_Z) ? ST_ACCEPTED : ST_MOVED;
              halted_d = rule_rdata.next_state && top_q == CODE_Z;
            end
            default: begin
              if (sp_q >= SpFull) begin
                status_d = ST_OVERFLOW;
                halted_d = 1'b1;
              end else begin
                stk_we   = 1'b1;
                state_d  = rule_rdata.next_state;
                top_d    = rule_rdata.act;
                sp_d     = sp_q + SpOne;
                status_d = (rule_rdata.next_state && rule_rdata.act == CODE_Z)
                           ? ST_ACCEPTED : ST_MOVED;
                halted_d = rule_rdata.next_state && rule_rdata.act == CODE_Z;
              end
            end
          endcase
        end
      end
      // new top arrives from the stack memory
      S_POP: begin
        top_d    = stk_rdata;
        status_d = (state_q && stk_rdata == CODE_Z) ? ST_ACCEPTED : ST_MOVED;
        halted_d = state_q && stk_rdata == CODE_Z;
      end
      default: ;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      start_q     <= 1'b0;
      state_q     <= 1'b0;
      top_q       <= CODE_Z;
      sp_q        <= SpOne;
      halted_q    <= 1'b0;
      status_q    <= ST_DONE;
      ridx_q      <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      start_q     <= start_d;
      state_q     <= state_d;
      top_q       <= top_d;
      sp_q        <= sp_d;
      halted_q    <= halted_d;
      status_q    <= status_d;
      ridx_q      <= ridx_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_status_q <= status_q;
      out_state_q  <= state_q;
      out_top_q    <= top_q;
      out_sp_q     <= sp_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign current_state_o = out_state_q;
  assign top_code_o      = out_top_q;
  assign stack_depth_o   = out_sp_q;

  // checks
  `TDPA_ASSERT_NOW(a_sp_bound, 1'b1, sp_q <= SpFull, "stack pointer beyond depth")
  `TDPA_ASSERT_NOW(a_empty_halts, sp_q == '0, halted_q, "empty stack while running")
  `TDPA_ASSERT_NOW(a_low_top_z, sp_q <= SpOne, top_q == CODE_Z, "top not Z at bottom")
  `TDPA_ASSERT_NEXT(a_halted_frozen, in_acc && op_e'(operation_i) == OP_FEED && halted_q,
                    $stable(sp_q) && $stable(state_q) && $stable(top_q),
                    "symbol changed state while halted")
  `TDPA_ASSERT_NEXT(a_emit_loads, emit_go, out_valid_q && fsm_q == S_IDLE,
                    "result not loaded on emit")

endmodule

/* test/tb_table_driven_pushdown_automaton.sv */
// ----------------------------------------------------------------------------
// Testbench for the bracket pushdown automaton
// Drives feed, rule-write, restart and unused-op items through the valid/ready input
// channel. A scoreboard keeps its own copy of the rule table, stack and
// automaton state, predicts one report per accepted item and checks every
// report on the output channel in order. Random phases run bracket sessions
// over a loaded rule set mixed with noise, under varying idle and stall rates.
// ----------------------------------------------------------------------------
module tb_table_driven_pushdown_automaton;
  timeunit 1ns;
  timeprecision 1ps;
  import tdpa_pkg::*;

  localparam int StackSize = 64;
  localparam int TableSize = 2 * NumSymbols * NumTops;
  localparam int ReportCap = 100;
  localparam int HoldCycles = 150;
  localparam int PhaseItems = 165;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] KIND_PUSH = 2'd3;

  // bracket characters and their symbol codes
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [1:0] SYM_LBRACE = 2'd0;
  localparam logic [1:0] SYM_LBRACK = 2'd1;
  localparam logic [1:0] SYM_RBRACE = 2'd2;
  localparam logic [1:0] SYM_RBRACK = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       r_state;
    logic [1:0] r_sym;
    logic [2:0] r_top;
    logic [1:0] r_kind;
    logic       r_next;
    logic [2:0] r_push;
  } pda_item_t;

  typedef struct packed {
    status_e    status;
    logic       state;
    logic [2:0] top;
    logic [6:0] depth;
  } pda_report_t;

  // automaton shadow: predicts reports and checks them in order
  class automaton_tracker;
    bit          entry_ok   [TableSize];
    logic        entry_next [TableSize];
    logic [2:0]  entry_act  [TableSize];
    logic [2:0]  stk [StackSize];
    int unsigned depth;
    logic        state;
    logic        start_state;
    bit          halted;
    pda_report_t expected_reports [$];
    int unsigned errors;
    int unsigned reports;
    int unsigned items;
    int unsigned status_seen [8];

    function new();
      foreach (entry_ok[i]) begin
        entry_ok[i]   = 1'b0;
        entry_next[i] = 1'b0;
        entry_act[i]  = 3'd0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      start_state = 1'b0;
      errors  = 0;
      reports = 0;
      items   = 0;
      restart();
    endfunction

    function void restart();
      foreach (stk[i]) stk[i] = 3'd0;
      stk[0] = CODE_Z;
      depth  = 1;
      state  = start_state;
      halted = 1'b0;
    endfunction

    function logic [2:0] top_code();
      return (depth == 0) ? CODE_Z : stk[depth-1];
    endfunction

    function bit accepting();
      return state == 1'b1 && depth > 0 && top_code() == CODE_Z;
    endfunction

    // turn a rule item into a table entry
    function void store_rule(pda_item_t it);
      logic [2:0] act;
      logic       nxt;
      int         idx;
      if (it.r_top >= NumTops) return;
      nxt = it.r_next;
      act = ACT_KEEP;
      if (it.r_kind != KIND_GOTO) begin
        nxt = it.r_state;
        if (it.r_kind == KIND_POP) act = ACT_POP;
        else if (it.r_kind == KIND_KEEP) act = ACT_KEEP;
        else if (it.r_push == CODE_P) act = ACT_POP;
        else if (it.r_push > CODE_Z) act = ACT_KEEP;
        else act = it.r_push;
      end
      // state 0 over the bottom marker pushes the symbol itself
      if (it.r_state == 1'b0 && it.r_top == CODE_Z) act = {1'b0, it.r_sym};
      idx = (int'(it.r_state) * NumSymbols + int'(it.r_sym)) * NumTops + int'(it.r_top);
      entry_ok[idx]   = 1'b1;
      entry_next[idx] = nxt;
      entry_act[idx]  = act;
    endfunction

    function status_e feed(logic [7:0] ch);
      int         code;
      int         idx;
      logic [2:0] act;
      if (halted) return ST_HALTED;
      if (accepting()) begin
        halted = 1'b1;
        return ST_ACCEPTED;
      end
      case (ch)
        CH_LBRACE: code = SYM_LBRACE;
        CH_LBRACK: code = SYM_LBRACK;
        CH_RBRACE: code = SYM_RBRACE;
        CH_RBRACK: code = SYM_RBRACK;
        default:   code = -1;
      endcase
      if (code < 0) begin
        halted = 1'b1;
        return ST_BAD_SYMBOL;
      end
      idx = (int'(state) * NumSymbols + code) * NumTops + int'(top_code());
      if (!entry_ok[idx]) begin
        halted = 1'b1;
        return ST_NO_RULE;
      end
      act = entry_act[idx];
      if (act == ACT_POP) begin
        state = entry_next[idx];
        if (depth > 0) depth = depth - 1;
        if (depth == 0) begin
          halted = 1'b1;
          return ST_EMPTIED;
        end
      end else if (act != ACT_KEEP) begin
        // full stack: nothing moves
        if (depth >= StackSize) begin
          halted = 1'b1;
          return ST_OVERFLOW;
        end
        state      = entry_next[idx];
        stk[depth] = act;
        depth      = depth + 1;
      end else begin
        state = entry_next[idx];
      end
      if (accepting()) begin
        halted = 1'b1;
        return ST_ACCEPTED;
      end
      return ST_MOVED;
    endfunction

    // accepted input item: predict its report
    function void note_item(pda_item_t it);
      pda_report_t r;
      r.status = ST_DONE;
      case (it.op)
        OP_FEED:    r.status = feed(it.ch);
        OP_RULE:    store_rule(it);
        OP_RESTART: restart();
        default: ;
      endcase
      r.state = state;
      r.top   = top_code();
      r.depth = 7'(depth);
      expected_reports.push_back(r);
      items = items + 1;
      status_seen[r.status] = status_seen[r.status] + 1;
    endfunction

    function void complain(string msg);
      errors = errors + 1;
      if (errors <= ReportCap) $display("%s", msg);
      else if (errors == ReportCap + 1) $display("further mismatches are counted only");
    endfunction

    // accepted report: compare with the oldest prediction
    function void check_result(pda_report_t got);
      pda_report_t want;
      if (expected_reports.size() == 0) begin
        complain($sformatf("%0t: report with nothing expected, status %0d", $time,
                           got.status));
        return;
      end
      want    = expected_reports.pop_front();
      reports = reports + 1;
      if (got.status !== want.status)
        complain($sformatf("%0t: status expected %0d got %0d", $time, want.status,
                           got.status));
      if (got.state !== want.state)
        complain($sformatf("%0t: current_state expected %0d got %0d", $time, want.state,
                           got.state));
      if (got.top !== want.top)
        complain($sformatf("%0t: top_code expected %0d got %0d", $time, want.top, got.top));
      if (got.depth !== want.depth)
        complain($sformatf("%0t: stack_depth expected %0d got %0d", $time, want.depth,
                           got.depth));
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] operation_i;
  logic [7:0] symbol_byte_i;
  logic       rule_state_i;
  logic [1:0] rule_symbol_i;
  logic [2:0] rule_stack_top_i;
  logic [1:0] rule_kind_i;
  logic       rule_next_state_i;
  logic [2:0] rule_push_code_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] status_o;
  logic       current_state_o;
  logic [2:0] top_code_o;
  logic [6:0] stack_depth_o;

  automaton_tracker tracker = new();
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int unsigned sent_count;

  table_driven_pushdown_automaton dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .symbol_byte_i     (symbol_byte_i),
    .rule_state_i      (rule_state_i),
    .rule_symbol_i     (rule_symbol_i),
    .rule_stack_top_i  (rule_stack_top_i),
    .rule_kind_i       (rule_kind_i),
    .rule_next_state_i (rule_next_state_i),
    .rule_push_code_i  (rule_push_code_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .current_state_o   (current_state_o),
    .top_code_o        (top_code_o),
    .stack_depth_o     (stack_depth_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb_table_driven_pushdown_automaton: done, errors");
    $finish;
  end

  // every unused field carries random bits
  function automatic pda_item_t junk_item();
    pda_item_t it;
    it.op      = 2'($urandom_range(0, 3));
    it.ch      = 8'($urandom_range(0, 255));
    it.r_state = 1'($urandom_range(0, 1));
    it.r_sym   = 2'($urandom_range(0, 3));
    it.r_top   = 3'($urandom_range(0, 7));
    it.r_kind  = 2'($urandom_range(0, 3));
    it.r_next  = 1'($urandom_range(0, 1));
    it.r_push  = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic pda_item_t feed_item(input logic [7:0] ch);
    pda_item_t it;
    it    = junk_item();
    it.op = OP_FEED;
    it.ch = ch;
    return it;
  endfunction

  function automatic pda_item_t op_item(input logic [1:0] op);
    pda_item_t it;
    it    = junk_item();
    it.op = op;
    return it;
  endfunction

  function automatic pda_item_t rule_item(input logic st, input logic [1:0] sym,
                                          input logic [2:0] top, input logic [1:0] kind,
                                          input logic nxt, input logic [2:0] push);
    pda_item_t it;
    it         = junk_item();
    it.op      = OP_RULE;
    it.r_state = st;
    it.r_sym   = sym;
    it.r_top   = top;
    it.r_kind  = kind;
    it.r_next  = nxt;
    it.r_push  = push;
    return it;
  endfunction

  function automatic logic [7:0] bracket_char(input logic [1:0] sym);
    case (sym)
      SYM_LBRACE: return CH_LBRACE;
      SYM_LBRACK: return CH_LBRACK;
      SYM_RBRACE: return CH_RBRACE;
      default:    return CH_RBRACK;
    endcase
  endfunction

  // offer one item, starting and ending on a falling edge
  task automatic push_item(input pda_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    operation_i       <= it.op;
    symbol_byte_i     <= it.ch;
    rule_state_i      <= it.r_state;
    rule_symbol_i     <= it.r_sym;
    rule_stack_top_i  <= it.r_top;
    rule_kind_i       <= it.r_kind;
    rule_next_state_i <= it.r_next;
    rule_push_code_i  <= it.r_push;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(it);
    sent_count = sent_count + 1;
    @(negedge clk_i);
  endtask

  // hold the input until every report is back, then let the pipe settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_reports.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_start_state(input logic v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.start_state = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // bracket matcher: first symbol is pushed and moves to state 1, openers
  // push, a closer pops its own opener, back at Z in state 1 accepts
  task automatic load_bracket_rules();
    for (int s = 0; s < NumSymbols; s++)
      push_item(rule_item(1'b0, 2'(s), CODE_Z, KIND_GOTO, 1'b1, 3'($urandom_range(0, 7))));
    for (int t = 0; t < 4; t++) begin
      push_item(rule_item(1'b1, SYM_LBRACE, 3'(t), KIND_PUSH, 1'b0, 3'(SYM_LBRACE)));
      push_item(rule_item(1'b1, SYM_LBRACK, 3'(t), KIND_PUSH, 1'b0, 3'(SYM_LBRACK)));
    end
    push_item(rule_item(1'b1, SYM_RBRACE, 3'(SYM_LBRACE), KIND_POP, 1'b1, 3'd0));
    push_item(rule_item(1'b1, SYM_RBRACK, 3'(SYM_LBRACK), KIND_POP, 1'b1, 3'd0));
  endtask

  // restart, then a random nesting walk with occasional stray characters
  task automatic bracket_session();
    logic [1:0] open_stk [$];
    logic [1:0] sym;
    int         target;
    int         steps;
    bit         reached;
    push_item(op_item(OP_RESTART));
    target  = ($urandom_range(0, 24) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 8);
    steps   = 0;
    reached = 1'b0;
    while (!tracker.halted && steps < 200) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) == 0) push_item(feed_item(8'($urandom_range(0, 255))));
        else push_item(feed_item(bracket_char(2'($urandom_range(0, 3)))));
      end else if (open_stk.size() == 0 ||
                   (open_stk.size() < target &&
                    $urandom_range(0, 99) < (reached ? 30 : 70))) begin
        sym = 2'($urandom_range(0, 1));
        open_stk.push_back(sym);
        push_item(feed_item(bracket_char(sym)));
        if (open_stk.size() >= target) reached = 1'b1;
      end else begin
        sym = open_stk.pop_back();
        push_item(feed_item(bracket_char(sym + 2'd2)));
      end
      steps++;
    end
    // sometimes poke the block once more, most often halted by then
    if ($urandom_range(0, 3) == 0) push_item(feed_item(bracket_char(2'($urandom_range(0, 3)))));
  endtask

  task automatic noise_burst();
    int pick;
    repeat ($urandom_range(1, 4)) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) push_item(feed_item(8'($urandom_range(0, 255))));
      else if (pick < 70) push_item(op_item(OP_RULE));
      else if (pick < 85) push_item(op_item(OP_UNUSED));
      else push_item(op_item(OP_RESTART));
    end
  endtask

  // report side: sample on the rising edge, decide ready on the falling edge
  initial begin
    pda_report_t seen;
    int          hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        seen.status = status_e'(status_o);
        seen.state  = current_state_o;
        seen.top    = top_code_o;
        seen.depth  = stack_depth_o;
        tracker.check_result(seen);
      end
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left   = hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // stimulus
  initial begin
    int unsigned phase_stop;
    int unsigned pause_at;
    int          pick;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_data_i        = 1'b0;
    in_valid_i        = 1'b0;
    operation_i       = OP_FEED;
    symbol_byte_i     = 8'd0;
    rule_state_i      = 1'b0;
    rule_symbol_i     = 2'd0;
    rule_stack_top_i  = 3'd0;
    rule_kind_i       = KIND_GOTO;
    rule_next_state_i = 1'b0;
    rule_push_code_i  = 3'd0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_req          = 1'b0;
    sent_count        = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    write_start_state(1'b0);

    // empty table, halting, unused op, out-of-range rule keys
    push_item(feed_item(CH_LBRACE));
    push_item(feed_item(CH_LBRACK));
    push_item(op_item(OP_UNUSED));
    push_item(rule_item(1'b1, 2'd3, 3'd6, 2'd3, 1'b1, 3'd7));
    push_item(rule_item(1'b0, 2'd0, 3'd7, KIND_GOTO, 1'b0, 3'd0));
    push_item(op_item(OP_RESTART));
    // forced push over Z, push of P, push code out of range, push of Z
    push_item(rule_item(1'b0, SYM_LBRACE, CODE_Z, KIND_GOTO, 1'b1, 3'd7));
    push_item(rule_item(1'b1, SYM_LBRACE, 3'd0, KIND_PUSH, 1'b0, CODE_P));
    push_item(rule_item(1'b1, SYM_LBRACK, 3'd0, KIND_PUSH, 1'b0, 3'd6));
    push_item(rule_item(1'b1, SYM_RBRACE, 3'd0, KIND_PUSH, 1'b0, CODE_Z));
    push_item(feed_item(CH_LBRACE));
    push_item(feed_item(CH_LBRACK));
    push_item(feed_item(CH_LBRACE));
    push_item(feed_item(CH_RBRACK));
    push_item(op_item(OP_RESTART));
    push_item(feed_item(CH_LBRACE));
    push_item(feed_item(CH_RBRACE));
    // bad characters at both ends of the byte range
    push_item(op_item(OP_RESTART));
    push_item(feed_item(8'h00));
    push_item(op_item(OP_RESTART));
    push_item(feed_item(8'hFF));
    // forced push with a pop kind keeps state 0
    push_item(rule_item(1'b0, SYM_RBRACK, CODE_Z, KIND_POP, 1'b1, 3'd7));
    push_item(op_item(OP_RESTART));
    push_item(feed_item(CH_RBRACK));

    // start in state 1: already accepting before any symbol
    wait_drain();
    write_start_state(1'b1);
    push_item(op_item(OP_RESTART));
    push_item(feed_item(CH_LBRACK));
    push_item(feed_item(CH_LBRACK));
    push_item(op_item(OP_UNUSED));
    push_item(op_item(OP_RESTART));

    // random phases
    for (int p = 0; p < 8; p++) begin
      wait_drain();
      write_start_state((p == 2 || p == 5) ? 1'b1 : 1'b0);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // long receiver hold-off while items keep coming
      if (p == 4) hold_req = 1'b1;
      phase_stop = sent_count + PhaseItems;
      pause_at   = (p == 6) ? sent_count + PhaseItems / 2 : 0;
      load_bracket_rules();
      while (sent_count < phase_stop) begin
        if (pause_at != 0 && sent_count >= pause_at) begin
          wait_drain();
          pause_at = 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) load_bracket_rules();
        else if (pick < 75) bracket_session();
        else noise_burst();
      end
    end

    wait_drain();
    $display("ran %0d items, checked %0d reports over both start states and eight phases",
             tracker.items, tracker.reports);
    $display("moved %0d accepted %0d no-rule %0d bad %0d overflow %0d halted %0d done %0d",
             tracker.status_seen[ST_MOVED], tracker.status_seen[ST_ACCEPTED],
             tracker.status_seen[ST_NO_RULE], tracker.status_seen[ST_BAD_SYMBOL],
             tracker.status_seen[ST_OVERFLOW], tracker.status_seen[ST_HALTED],
             tracker.status_seen[ST_DONE]);
    if (tracker.errors == 0 && tracker.expected_reports.size() == 0) begin
      $display("tb_table_driven_pushdown_automaton: done, clean");
    end else begin
      $display("tb_table_driven_pushdown_automaton: done, errors");
    end
    $finish;
  end

endmodule
